>>> rtl/ggc_pkg.sv
package ggc_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_COLORS   = 64;
    localparam int VERTEX_W     = 10;
    localparam int COLOR_W      = 6;
    localparam int COUNT_W      = 7;
    localparam int EPOCH_W      = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    localparam int TUSER_RESTART = 0;
    localparam int TUSER_NVALID  = 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int GRP_W = 8;
    localparam int GRP_N = MAX_COLORS / GRP_W;

    typedef struct packed {
        logic                restart;
        logic [VERTEX_W-1:0] vertex;
        logic [VERTEX_W-1:0] neighbor;
        logic                nvalid;
        logic                last;
        logic [EPOCH_W-1:0]  epoch;
    } item_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [COLOR_W-1:0] color;
    } entry_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pick;
        logic               over;
    } mex_t;

    typedef struct packed {
        logic clr_busy;
        logic pipe_idle;
    } back_status_t;

    function automatic logic [MAX_COLORS-1:0] color_bit(input logic [COLOR_W-1:0] color);
        color_bit = {{(MAX_COLORS-1){1'b0}}, 1'b1} << color;
    endfunction

    // Smallest clear bit, found per byte group first and then across groups.
    function automatic mex_t mex_of(input logic [MAX_COLORS-1:0] seen);
        logic [GRP_N-1:0] grp_free;
        logic [COLOR_W-1:0] grp_idx [GRP_N];
        mex_t r;
        for (int g = 0; g < GRP_N; g++) begin
            grp_free[g] = ~&seen[g*GRP_W +: GRP_W];
            grp_idx[g]  = COLOR_W'(g * GRP_W);
            for (int b = GRP_W - 1; b >= 0; b--) begin
                if (!seen[g*GRP_W + b]) begin
                    grp_idx[g] = COLOR_W'(g * GRP_W + b);
                end
            end
        end
        r.pick = COLOR_W'(MAX_COLORS - 1);
        r.over = 1'b1;
        for (int g = GRP_N - 1; g >= 0; g--) begin
            if (grp_free[g]) begin
                r.pick = grp_idx[g];
                r.over = 1'b0;
            end
        end
        mex_of = r;
    endfunction

endpackage

>>> rtl/ggc_queue.sv
module ggc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ggc_pkg::item_t push_item,
    input  logic           pop,
    output ggc_pkg::item_t head,
    output logic           empty,
    output logic           full
);

    ggc_pkg::item_t                    slot_reg [ggc_pkg::QUEUE_DEPTH];
    logic [ggc_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [ggc_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [ggc_pkg::QCNT_W-1:0]        count_reg;
    logic [ggc_pkg::QCNT_W-1:0]        count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == ggc_pkg::QCNT_W'(ggc_pkg::QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/ggc_front.sv
module ggc_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ggc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [ggc_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          s_tlast,
    input  logic                          q_full,
    input  logic                          q_empty,
    output logic                          push,
    output ggc_pkg::item_t                push_item,
    input  ggc_pkg::back_status_t         back_status,
    output logic                          clr_start
);

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic [ggc_pkg::EPOCH_W-1:0]   epoch_reg;
    logic [ggc_pkg::EPOCH_W-1:0]   epoch_next;
    logic                          restart;
    logic                          need_wrap;

    assign restart   = s_tuser[ggc_pkg::TUSER_RESTART];
    assign need_wrap = s_tvalid && restart && (epoch_reg == ggc_pkg::EPOCH_MAX);
    assign s_tready  = (state_reg == ST_RUN) && !q_full && !back_status.clr_busy && !need_wrap;
    assign push      = s_tvalid && s_tready;

    always_comb begin
        push_item          = '0;
        push_item.restart  = restart;
        push_item.vertex   = s_tdata[ggc_pkg::VERTEX_W-1:0];
        push_item.neighbor = s_tdata[2*ggc_pkg::VERTEX_W-1:ggc_pkg::VERTEX_W];
        push_item.nvalid   = s_tuser[ggc_pkg::TUSER_NVALID];
        push_item.last     = s_tlast;
        push_item.epoch    = restart ? epoch_reg + 1'b1 : epoch_reg;
    end

    always_comb begin
        state_next = state_reg;
        epoch_next = epoch_reg;
        clr_start  = 1'b0;
        unique case (state_reg)
            ST_RUN: begin
                if (push) begin
                    epoch_next = push_item.epoch;
                end else if (need_wrap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (q_empty && back_status.pipe_idle && !back_status.clr_busy) begin
                    clr_start  = 1'b1;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (!back_status.clr_busy) begin
                    epoch_next = '0;
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            epoch_reg <= ggc_pkg::EPOCH_W'(1);
        end else begin
            state_reg <= state_next;
            epoch_reg <= epoch_next;
        end
    end

endmodule

>>> rtl/ggc_back.sv
module ggc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ggc_pkg::item_t                q_head,
    input  logic                          q_empty,
    output logic                          pop,
    input  logic                          clr_start,
    output ggc_pkg::back_status_t         back_status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ggc_pkg::M_TDATA_W-1:0] m_tdata
);

    ggc_pkg::entry_t store_mem [ggc_pkg::MAX_VERTICES];

    logic                            adv;
    logic                            clr_busy_reg;
    logic [ggc_pkg::VERTEX_W-1:0]    clr_addr_reg;

    logic                            b_valid_reg;
    ggc_pkg::item_t                  b_item_reg;
    ggc_pkg::entry_t                 rd_q_reg;
    logic [ggc_pkg::MAX_COLORS-1:0]  seen_reg;
    logic [ggc_pkg::MAX_COLORS-1:0]  seen_next;
    logic                            defer_reg;
    logic                            defer_next;
    logic                            rs_reg;
    logic                            rs_next;

    logic                            c_valid_reg;
    logic [ggc_pkg::VERTEX_W-1:0]    c_vertex_reg;
    logic [ggc_pkg::EPOCH_W-1:0]     c_epoch_reg;
    logic [ggc_pkg::MAX_COLORS-1:0]  c_seen_reg;
    logic                            c_defer_reg;
    logic                            c_rs_reg;

    logic                            w_valid_reg;
    logic [ggc_pkg::VERTEX_W-1:0]    w_vertex_reg;
    logic [ggc_pkg::COLOR_W-1:0]     w_color_reg;
    logic [ggc_pkg::EPOCH_W-1:0]     w_epoch_reg;

    logic [ggc_pkg::COUNT_W-1:0]     count_reg;
    logic [ggc_pkg::COUNT_W-1:0]     count_next;
    logic                            m_valid_reg;
    logic [ggc_pkg::M_TDATA_W-1:0]   m_tdata_reg;

    logic [ggc_pkg::MAX_COLORS-1:0]  w_bits;
    logic [ggc_pkg::MAX_COLORS-1:0]  base;
    logic                            hit_c;
    logic                            hit_w;
    logic                            known;
    logic [ggc_pkg::COLOR_W-1:0]     nb_color;
    logic [ggc_pkg::MAX_COLORS-1:0]  acc;
    logic [ggc_pkg::MAX_COLORS-1:0]  c_bitmap;
    ggc_pkg::mex_t                   mex;
    logic [ggc_pkg::COUNT_W-1:0]     count_base;
    logic [ggc_pkg::COUNT_W-1:0]     count_cand;

    assign adv  = !m_valid_reg || m_tready;
    assign pop  = adv && !q_empty && !clr_busy_reg;
    assign back_status.clr_busy  = clr_busy_reg;
    assign back_status.pipe_idle = !b_valid_reg && !c_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    // A neighbor whose vertex sits in the mex stage takes its color from the write-back
    // register once that vertex has moved on.
    assign w_bits = ggc_pkg::color_bit(w_color_reg);

    always_comb begin
        hit_c = c_valid_reg && (c_epoch_reg == b_item_reg.epoch)
                && (c_vertex_reg == b_item_reg.neighbor);
        hit_w = w_valid_reg && (w_epoch_reg == b_item_reg.epoch)
                && (w_vertex_reg == b_item_reg.neighbor);
        nb_color = hit_w ? w_color_reg : rd_q_reg.color;
        known = b_item_reg.nvalid && !hit_c && (hit_w || (rd_q_reg.epoch == b_item_reg.epoch));
        base  = b_item_reg.restart ? '0 : (seen_reg | (defer_reg ? w_bits : '0));
        acc   = base | (known ? ggc_pkg::color_bit(nb_color) : '0);

        if (!b_valid_reg) begin
            seen_next  = seen_reg | (defer_reg ? w_bits : '0);
            defer_next = 1'b0;
            rs_next    = rs_reg;
        end else if (b_item_reg.last) begin
            seen_next  = '0;
            defer_next = 1'b0;
            rs_next    = 1'b0;
        end else begin
            seen_next  = acc;
            defer_next = b_item_reg.nvalid && hit_c;
            rs_next    = rs_reg || b_item_reg.restart;
        end
    end

    always_comb begin
        c_bitmap   = c_seen_reg | (c_defer_reg ? w_bits : '0);
        mex        = ggc_pkg::mex_of(c_bitmap);
        count_base = c_rs_reg ? '0 : count_reg;
        count_cand = {1'b0, mex.pick} + 1'b1;
        count_next = (count_cand > count_base) ? count_cand : count_base;
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            store_mem[clr_addr_reg] <= '0;
        end else if (adv && c_valid_reg) begin
            store_mem[c_vertex_reg] <= {c_epoch_reg, mex.pick};
        end
        if (adv) begin
            rd_q_reg <= store_mem[q_head.neighbor];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_start) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ggc_pkg::VERTEX_W'(ggc_pkg::MAX_VERTICES - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            seen_reg    <= '0;
            defer_reg   <= 1'b0;
            rs_reg      <= 1'b0;
            c_valid_reg <= 1'b0;
            w_valid_reg <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                b_valid_reg <= pop;
                seen_reg    <= seen_next;
                defer_reg   <= defer_next;
                rs_reg      <= rs_next;
                c_valid_reg <= b_valid_reg && b_item_reg.last;
                m_valid_reg <= c_valid_reg;
                if (c_valid_reg) begin
                    count_reg <= count_next;
                end
            end
            if (clr_start) begin
                w_valid_reg <= 1'b0;
            end else if (adv && c_valid_reg) begin
                w_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_item_reg   <= q_head;
            c_vertex_reg <= b_item_reg.vertex;
            c_epoch_reg  <= b_item_reg.epoch;
            c_seen_reg   <= acc;
            c_defer_reg  <= b_item_reg.nvalid && hit_c;
            c_rs_reg     <= rs_reg || b_item_reg.restart;
            if (c_valid_reg) begin
                w_vertex_reg <= c_vertex_reg;
                w_color_reg  <= mex.pick;
                w_epoch_reg  <= c_epoch_reg;
                m_tdata_reg  <= {mex.over, count_next, mex.pick, c_vertex_reg};
            end
        end
    end

endmodule

>>> rtl/greedy_graph_coloring_unit.sv
// First-fit greedy vertex coloring.
// The input stream carries one request per neighbor of the vertex being colored;
// tlast marks the final neighbor of a vertex, and the vertex field must be valid on it.
// A vertex without neighbors sends one request with the neighbor-valid flag low.
// The restart flag on a request starts a new coloring before that request is used.
// On every last request one result leaves on the output stream: the vertex, its color
// (smallest color not held by an already colored neighbor), the number of colors used
// and an overflow flag when all 64 colors were taken.
// Throughput is one request per cycle unless the queue is full, a sweep runs or the
// receiver stalls. A last request passes the queue, the color store read, the bitmap
// update and the mex stage before its result is registered at the output. After reset
// all 1024 store entries are swept with s_tready low. Restarts are tagged with an 8-bit
// generation; every 255th restart waits for the pipeline to drain, then sweeps again.
// When the receiver stalls, the result is held in the output register and the back
// pipeline halts; a four-entry queue keeps accepting until it is full.
module greedy_graph_coloring_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ggc_pkg::S_TDATA_W-1:0] s_tdata,  // vertex, neighbor, zero fill
    input  logic [ggc_pkg::S_TUSER_W-1:0] s_tuser,  // restart, neighbor_valid
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ggc_pkg::M_TDATA_W-1:0] m_tdata   // vertex_out, color, colors_used, overflow
);

    logic                  push;
    ggc_pkg::item_t        push_item;
    logic                  pop;
    ggc_pkg::item_t        q_head;
    logic                  q_empty;
    logic                  q_full;
    logic                  clr_start;
    ggc_pkg::back_status_t back_status;

    ggc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .q_empty     (q_empty),
        .push        (push),
        .push_item   (push_item),
        .back_status (back_status),
        .clr_start   (clr_start)
    );

    ggc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    ggc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_head      (q_head),
        .q_empty     (q_empty),
        .pop         (pop),
        .clr_start   (clr_start),
        .back_status (back_status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

>>> rtl/ggc_checker.sv
module ggc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ggc_pkg::M_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_count_covers_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[22:16] > {1'b0, m_tdata[15:10]}))
        else $error("colors_used does not cover the color");

    a_overflow_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[23] |-> (m_tdata[15:10] == 6'(ggc_pkg::MAX_COLORS - 1)))
        else $error("overflow without the top color");

    a_sweep_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready && !m_tvalid)
        else $error("ready during the store sweep after reset");

endmodule

bind greedy_graph_coloring_unit ggc_checker u_ggc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> dv/tb_greedy_graph_coloring_unit.sv
`timescale 1ns / 100ps

module tb_greedy_graph_coloring_unit;

    localparam int VW = ggc_pkg::VERTEX_W;
    localparam int CW = ggc_pkg::COLOR_W;
    localparam int NW = ggc_pkg::COUNT_W;
    localparam int NCOLORS = ggc_pkg::MAX_COLORS;
    localparam int NVERTS = ggc_pkg::MAX_VERTICES;
    localparam int CLIQUE_N = 24;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic          restart;
        logic [VW-1:0] vertex;
        logic [VW-1:0] neighbor;
        logic          nvalid;
        logic          last;
    } nbr_req_t;

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic [CW-1:0] color;
        logic [NW-1:0] used;
        logic          over;
    } coloring_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ggc_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [ggc_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [ggc_pkg::M_TDATA_W-1:0] m_tdata;

    greedy_graph_coloring_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    nbr_req_t  pending_reqs[$];
    coloring_t colorings_due[$];
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int reqs_queued = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // Shadow of the block's color store, colored marks, seen bitmap and color count.
    logic [CW-1:0]      vertex_color [NVERTS];
    logic [NVERTS-1:0]  colored = '0;
    logic [NCOLORS-1:0] seen_bits = '0;
    logic [NW-1:0]      used_count = '0;

    task automatic first_fit_update(input nbr_req_t r);
        coloring_t res;
        if (r.restart) begin
            colored = '0;
            seen_bits = '0;
            used_count = '0;
        end
        if (r.nvalid && colored[r.neighbor]) begin
            seen_bits[vertex_color[r.neighbor]] = 1'b1;
        end
        if (r.last) begin
            res.vertex = r.vertex;
            res.color = CW'(NCOLORS - 1);
            res.over = 1'b1;
            for (int c = NCOLORS - 1; c >= 0; c--) begin
                if (!seen_bits[c]) begin
                    res.color = CW'(c);
                    res.over = 1'b0;
                end
            end
            vertex_color[r.vertex] = res.color;
            colored[r.vertex] = 1'b1;
            seen_bits = '0;
            if (NW'(res.color) + 1'b1 > used_count) begin
                used_count = NW'(res.color) + 1'b1;
            end
            res.used = used_count;
            colorings_due.push_back(res);
        end
    endtask

    task automatic queue_req(input logic rs, input int v, input int nb, input logic nv,
                             input logic lst);
        nbr_req_t r;
        r.restart = rs;
        r.vertex = VW'(v);
        r.neighbor = VW'(nb);
        r.nvalid = nv;
        r.last = lst;
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    task automatic queue_directed();
        queue_req(1'b1, 0, 0, 1'b0, 1'b1);
        queue_req(1'b0, 1023, 0, 1'b1, 1'b1);
        queue_req(1'b0, 5, 700, 1'b1, 1'b0);
        queue_req(1'b0, 5, 1023, 1'b1, 1'b0);
        queue_req(1'b0, 5, 0, 1'b1, 1'b1);
        queue_req(1'b0, 6, 1023, 1'b0, 1'b0);
        queue_req(1'b0, 6, 5, 1'b1, 1'b1);
        queue_req(1'b0, 7, 0, 1'b1, 1'b0);
        queue_req(1'b0, 7, 1023, 1'b1, 1'b0);
        queue_req(1'b1, 7, 5, 1'b1, 1'b1);
        queue_req(1'b0, 8, 7, 1'b1, 1'b0);
        queue_req(1'b0, 9, 7, 1'b1, 1'b1);
        queue_req(1'b0, 9, 9, 1'b1, 1'b1);
        queue_req(1'b0, 9, 9, 1'b1, 1'b0);
        queue_req(1'b0, 9, 7, 1'b1, 1'b1);
        queue_req(1'b0, 10, 9, 1'b1, 1'b0);
        queue_req(1'b0, 10, 9, 1'b0, 1'b1);
        queue_req(1'b0, 11, 7, 1'b1, 1'b0);
        queue_req(1'b0, 11, 7, 1'b1, 1'b1);
        queue_req(1'b0, 682, 341, 1'b1, 1'b1);
        queue_req(1'b0, 341, 682, 1'b1, 1'b1);
    endtask

    // Small random graphs: most neighbors come from the graph's own vertex set.
    task automatic queue_graphs(input int n_reqs);
        int start;
        int nverts;
        int deg;
        int v;
        int nb;
        int pool [40];
        start = reqs_queued;
        while (reqs_queued - start < n_reqs) begin
            nverts = $urandom_range(40, 3);
            for (int i = 0; i < nverts; i++) begin
                pool[i] = $urandom_range(NVERTS - 1);
            end
            for (int k = 0; k < nverts; k++) begin
                v = ($urandom_range(9) == 0) ? pool[$urandom_range(nverts - 1)] : pool[k];
                deg = ($urandom_range(5) == 0) ? 0 : $urandom_range(8, 1);
                if (deg == 0) begin
                    queue_req(k == 0, v, $urandom_range(NVERTS - 1), 1'b0, 1'b1);
                end
                for (int j = 0; j < deg; j++) begin
                    nb = ($urandom_range(4) == 0) ? $urandom_range(NVERTS - 1)
                                                  : pool[$urandom_range(nverts - 1)];
                    queue_req((k == 0 && j == 0) || $urandom_range(49) == 0,
                              (j != deg - 1 && $urandom_range(19) == 0)
                                  ? $urandom_range(NVERTS - 1) : v,
                              nb, $urandom_range(9) != 0, j == deg - 1);
                end
            end
        end
    endtask

    // Many short colorings, enough restarts to wrap the block's restart generation.
    task automatic queue_restart_storm(input int n_runs);
        int len;
        for (int i = 0; i < n_runs; i++) begin
            len = $urandom_range(2, 1);
            for (int j = 0; j < len; j++) begin
                queue_req(j == 0 || $urandom_range(9) == 0, $urandom_range(NVERTS - 1),
                          $urandom_range(NVERTS - 1), $urandom_range(1) != 0, j == len - 1);
            end
        end
    endtask

    // A 24-clique in random order, then vertices adjacent to all, or all but one, of it.
    task automatic queue_clique();
        int perm [NVERTS];
        int nbrs [CLIQUE_N];
        int n;
        int skip;
        int j;
        int tmp;
        for (int i = 0; i < NVERTS; i++) begin
            perm[i] = i;
        end
        for (int i = NVERTS - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int k = 0; k < CLIQUE_N + 3; k++) begin
            skip = -1;
            if (k == CLIQUE_N + 1) begin
                skip = $urandom_range(CLIQUE_N - 2);
            end else if (k == CLIQUE_N + 2) begin
                skip = CLIQUE_N - 1;
            end
            n = 0;
            for (int i = 0; i < CLIQUE_N && i < k; i++) begin
                if (i != skip) begin
                    nbrs[n] = perm[i];
                    n++;
                end
            end
            for (int i = n - 1; i > 0; i--) begin
                j = $urandom_range(i);
                tmp = nbrs[i];
                nbrs[i] = nbrs[j];
                nbrs[j] = tmp;
            end
            if (n == 0) begin
                queue_req(1'b1, perm[k], perm[NVERTS - 1], 1'b0, 1'b1);
            end
            for (int i = 0; i < n; i++) begin
                queue_req(1'b0, perm[k], nbrs[i], 1'b1, i == n - 1);
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_tvalid || colorings_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (16) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        nbr_req_t acc;
        nbr_req_t nxt;
        logic [ggc_pkg::S_TUSER_W-1:0] user_nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                acc.restart = s_tuser[ggc_pkg::TUSER_RESTART];
                acc.nvalid = s_tuser[ggc_pkg::TUSER_NVALID];
                acc.vertex = s_tdata[VW-1:0];
                acc.neighbor = s_tdata[2*VW-1:VW];
                acc.last = s_tlast;
                first_fit_update(acc);
            end
            if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                nxt = pending_reqs.pop_front();
                user_nxt = '0;
                user_nxt[ggc_pkg::TUSER_RESTART] = nxt.restart;
                user_nxt[ggc_pkg::TUSER_NVALID] = nxt.nvalid;
                s_tdata <= {{(ggc_pkg::S_TDATA_W - 2*VW){1'b0}}, nxt.neighbor, nxt.vertex};
                s_tuser <= user_nxt;
                s_tlast <= nxt.last;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        coloring_t got;
        coloring_t want;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got.vertex = m_tdata[VW-1:0];
            got.color = m_tdata[VW+CW-1:VW];
            got.used = m_tdata[VW+CW+NW-1:VW+CW];
            got.over = m_tdata[VW+CW+NW];
            if (colorings_due.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected result: vertex %0d color %0d used %0d overflow %0b",
                             got.vertex, got.color, got.used, got.over);
                end
                mismatch_count++;
            end else begin
                want = colorings_due.pop_front();
                if (got !== want) begin
                    if (mismatch_count < 10) begin
                        $display("result differs: vertex %0d/%0d color %0d/%0d used %0d/%0d %s",
                                 got.vertex, want.vertex, got.color, want.color,
                                 got.used, want.used,
                                 $sformatf("overflow %0b/%0b (got/expected)",
                                           got.over, want.over));
                    end
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("greedy_graph_coloring_unit: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        queue_directed();
        queue_graphs(100);
        wait_idle();

        sender_idle_pct = 60;
        queue_restart_storm(270);
        queue_graphs(100);
        wait_idle();

        sender_idle_pct = 0;
        recv_stall_pct = 60;
        queue_graphs(150);
        wait_idle();

        sender_idle_pct = 18;
        recv_stall_pct = 18;
        queue_clique();
        queue_graphs(80);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("greedy_graph_coloring_unit: match");
        end else begin
            $display("greedy_graph_coloring_unit: mismatch");
        end
        $finish;
    end

endmodule
